// ===== rtl/lfbd_pkg.sv =====
// ---------------------------------------------------------------------------
// lfbd_pkg: shared types and constants for the length framed byte deframer
// Frame bytes, store geometry, phase codes and the frame descriptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfbd_pkg;

  // Frame bytes
  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] END_BYTE     = 8'hFE;
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;

  // Store size and result limit
  localparam int MAX_PAYLOAD  = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int EMIT_LIMIT   = (MAX_PAYLOAD < RESULT_LIMIT) ? MAX_PAYLOAD : RESULT_LIMIT;

  // Store geometry: two banks, one frame each
  localparam int SLOT_W    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W    = SLOT_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int CNT_W     = $clog2(EMIT_LIMIT + 1);

  // Front phases, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_END     = 4'b1000
  } phase_t;

  // Store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Accepted frame: bank and payload word count
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/lfbd_ram.sv =====
// ---------------------------------------------------------------------------
// lfbd_ram: generic simple dual port RAM
// One write port, one read port with registered and held read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfbd_front.sv =====
// ---------------------------------------------------------------------------
// lfbd_front: frame parser
// Hunts for the start word, takes the length, stores the payload and checks
// the end word; a good frame is handed on as a descriptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               q_full,
  output logic                    push,
  output lfbd_pkg::desc_t         push_desc,
  output lfbd_pkg::wr_t           wr
);

  lfbd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       exp_r, exp_nxt;
  logic [7:0]       rcv_r, rcv_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [7:0]       rcv_inc;

  // Stall only when both banks wait for the back end
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign rcv_inc  = rcv_r + 8'd1;

  // Store write for payload words that fit
  always_comb begin
    wr.en   = accept && (phase_r == lfbd_pkg::PH_PAYLOAD) &&
              ({24'd0, rcv_r} < lfbd_pkg::MAX_PAYLOAD);
    wr.addr = {bank_r, rcv_r[lfbd_pkg::SLOT_W-1:0]};
    wr.data = in_rx_byte;
  end

  // Advance the phase on each accepted word
  always_comb begin
    phase_nxt       = phase_r;
    exp_nxt         = exp_r;
    rcv_nxt         = rcv_r;
    bank_nxt        = bank_r;
    push            = 1'b0;
    push_desc.bank  = bank_r;
    push_desc.count = rcv_r[lfbd_pkg::CNT_W-1:0];
    if (accept) begin
      unique case (phase_r)
        lfbd_pkg::PH_HUNT: begin
          if (in_rx_byte == lfbd_pkg::START_BYTE) begin
            phase_nxt = lfbd_pkg::PH_LENGTH;
            exp_nxt   = 8'd0;
            rcv_nxt   = 8'd0;
          end
        end
        lfbd_pkg::PH_LENGTH: begin
          exp_nxt   = (in_rx_byte > lfbd_pkg::LEN_OVERHEAD) ?
                      (in_rx_byte - lfbd_pkg::LEN_OVERHEAD) : 8'd1;
          phase_nxt = lfbd_pkg::PH_PAYLOAD;
        end
        lfbd_pkg::PH_PAYLOAD: begin
          rcv_nxt = rcv_inc;
          if (rcv_inc >= exp_r) begin
            phase_nxt = lfbd_pkg::PH_END;
          end
        end
        lfbd_pkg::PH_END: begin
          // Hand on a good frame and switch banks; drop anything else
          if (in_rx_byte == lfbd_pkg::END_BYTE &&
              {24'd0, rcv_r} <= lfbd_pkg::EMIT_LIMIT) begin
            push     = 1'b1;
            bank_nxt = !bank_r;
          end
          phase_nxt = lfbd_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = lfbd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lfbd_pkg::PH_HUNT;
      exp_r   <= 8'd0;
      rcv_r   <= 8'd0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      rcv_r   <= rcv_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfbd_queue.sv =====
// ---------------------------------------------------------------------------
// lfbd_queue: two entry descriptor queue
// Holds accepted frames between parser and emitter, one per store bank.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lfbd_pkg::desc_t push_desc,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output lfbd_pkg::desc_t      head
);

  lfbd_pkg::desc_t ent_r [2];
  logic            wptr_r, wptr_nxt;
  logic            rptr_r, rptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfbd_back.sv =====
// ---------------------------------------------------------------------------
// lfbd_back: payload emitter
// Reads a stored frame word by word and presents it with index and last mark.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfbd_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         head_valid,
  input  wire lfbd_pkg::desc_t              head,
  output logic                              pop,
  output logic                              rd_en,
  output logic [lfbd_pkg::ADDR_W-1:0]       rd_addr,
  input  wire logic [7:0]                   rd_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_payload_byte,
  output logic [5:0]                        out_byte_index,
  output logic                              out_last
);

  logic [lfbd_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [lfbd_pkg::SLOT_W-1:0] pend_idx_r;
  logic                        pend_last_r;
  logic                        ov_r, ov_nxt;
  logic [7:0]                  ob_r;
  logic [5:0]                  oi_r;
  logic                        ol_r;
  logic                        load, is_last;

  // Move read data into the output register when it is free
  assign load    = pend_r && (!ov_r || out_ready);
  // Issue a read when the read data register is free or emptying
  assign rd_en   = head_valid && (!pend_r || load);
  assign rd_addr = {head.bank, idx_r};
  assign is_last = (lfbd_pkg::CNT_W'(idx_r) + lfbd_pkg::CNT_W'(1) == head.count);
  // Free the bank once its final read is issued
  assign pop     = rd_en && is_last;

  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = pend_r;
    ov_nxt   = ov_r;
    if (rd_en) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
    end
    if (rd_en) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Track index and last mark of the read in flight
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx_r  <= idx_r;
      pend_last_r <= is_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= rd_data;
      oi_r <= 6'(pend_idx_r);
      ol_r <= pend_last_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_payload_byte = ob_r;
  assign out_byte_index   = oi_r;
  assign out_last         = ol_r;

endmodule

`default_nettype wire

// ===== rtl/length_framed_byte_deframer.sv =====
// ---------------------------------------------------------------------------
// length_framed_byte_deframer: start/length/payload/end byte deframer
// Takes one byte per word and emits the payload of each good frame.
// ---------------------------------------------------------------------------
// Input: one word per cycle; stalls only while two good frames wait to be sent.
// With the emitter idle, taking the end word queues the descriptor; the first
// payload word is then read from the store and registered at the output.
// Output: one payload word per cycle while out_ready is high, set by the single store read port.
// Reset: synchronous, active low; parser hunts, queue and output are empty.
// The payload store is two banks of RAM with no reset or clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module length_framed_byte_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic [5:0]      out_byte_index,
  output logic            out_last
);

  logic                          q_full;
  logic                          push;
  lfbd_pkg::desc_t               push_desc;
  lfbd_pkg::wr_t                 wr;
  logic                          pop;
  logic                          head_valid;
  lfbd_pkg::desc_t               head;
  logic                          rd_en;
  logic [lfbd_pkg::ADDR_W-1:0]   rd_addr;
  logic [7:0]                    rd_data;

  // Parse and store frames
  lfbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc),
    .wr         (wr)
  );

  // Hold good frames
  lfbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Payload store
  lfbd_ram #(
    .WIDTH (8),
    .DEPTH (lfbd_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Emit payload
  lfbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/length_framed_byte_deframer_tb.sv =====
// ---------------------------------------------------------------------------
// length_framed_byte_deframer_tb: self-checking bench for the byte deframer
// Feeds framed and unframed byte streams through the valid/ready input,
// predicts the payload words from a behavioral model of the frame parser or the
// directed rows and compares each output word, field by field, under several idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_framed_byte_deframer_tb;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 10;
  localparam int END_LAT    = 12;
  localparam int MAX_CYCLES = 300000;
  localparam int HOLD_OFF   = 300;
  localparam int MAX_REPORT = 10;

  // One payload word as seen on the output channel
  typedef struct packed {
    logic [7:0] pb;
    logic [5:0] idx;
    logic       lst;
  } payload_word_t;

  // How a directed row gets its expected words
  typedef enum logic [1:0] {
    ROW_PRED,  // from the frame predictor
    ROW_NONE,  // no word follows
    ROW_ONE    // exactly one word: pb, index 0, last set
  } row_kind_t;

  typedef struct packed {
    logic [7:0] rx;
    row_kind_t  kind;
    logic [7:0] pb;
  } dir_row_t;

  // Directed stream: noise, short lengths, start byte inside a frame,
  // bad end bytes (including a start byte in the end position)
  localparam dir_row_t DIR_ROWS [24] = '{
    '{8'h00, ROW_NONE, 8'h00},  // noise while hunting
    '{8'hFE, ROW_NONE, 8'h00},  // end byte while hunting
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'h00, ROW_NONE, 8'h00},  // length 0 -> one payload word
    '{8'hA5, ROW_NONE, 8'h00},
    '{8'hFE, ROW_ONE,  8'hA5},
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'h03, ROW_NONE, 8'h00},  // length 3 -> one payload word
    '{8'hFF, ROW_NONE, 8'h00},  // start byte taken as payload
    '{8'hFE, ROW_ONE,  8'hFF},
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'h06, ROW_NONE, 8'h00},
    '{8'h00, ROW_NONE, 8'h00},
    '{8'h5A, ROW_NONE, 8'h00},
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'hFE, ROW_PRED, 8'h00},
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'h02, ROW_NONE, 8'h00},
    '{8'h7E, ROW_NONE, 8'h00},
    '{8'hFF, ROW_NONE, 8'h00},  // start byte in end position drops frame
    '{8'hFF, ROW_NONE, 8'h00},
    '{8'h04, ROW_NONE, 8'h00},
    '{8'h81, ROW_NONE, 8'h00},
    '{8'h00, ROW_NONE, 8'h00}   // wrong end byte drops frame
  };

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_last;

  // Bench bookkeeping
  payload_word_t expected_words [$];
  payload_word_t frame_words [$];
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  logic hold_on      = 1'b0;
  int err_cnt        = 0;
  int words_in       = 0;
  int words_checked  = 0;
  int cycle_cnt      = 0;

  // Frame parser model state
  lfbd_pkg::phase_t fr_phase = lfbd_pkg::PH_HUNT;
  logic [7:0]       fr_need  = 8'd0;
  logic [7:0]       fr_got   = 8'd0;
  logic [7:0]       fr_store [lfbd_pkg::MAX_PAYLOAD];

  length_framed_byte_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, expected_words.size());
      $display("length_framed_byte_deframer_tb NOT OK");
      $finish;
    end
  end

  // Advance the parser model by one byte; fill frame_words with its output
  function automatic void deframe_byte(input logic [7:0] b);
    payload_word_t w;
    frame_words.delete();
    case (fr_phase)
      lfbd_pkg::PH_HUNT: begin
        if (b == lfbd_pkg::START_BYTE) begin
          fr_phase = lfbd_pkg::PH_LENGTH;
          fr_need  = 8'd0;
          fr_got   = 8'd0;
        end
      end
      lfbd_pkg::PH_LENGTH: begin
        fr_need  = (b > lfbd_pkg::LEN_OVERHEAD) ? b - lfbd_pkg::LEN_OVERHEAD : 8'd1;
        fr_phase = lfbd_pkg::PH_PAYLOAD;
      end
      lfbd_pkg::PH_PAYLOAD: begin
        if (int'(fr_got) < lfbd_pkg::MAX_PAYLOAD) fr_store[fr_got[5:0]] = b;
        fr_got = fr_got + 8'd1;
        if (fr_got >= fr_need) fr_phase = lfbd_pkg::PH_END;
      end
      default: begin
        if (b == lfbd_pkg::END_BYTE && int'(fr_got) <= lfbd_pkg::EMIT_LIMIT) begin
          for (int k = 0; k < int'(fr_got); k++) begin
            w.pb  = fr_store[k];
            w.idx = k[5:0];
            w.lst = (k + 1 == int'(fr_got));
            frame_words.push_back(w);
          end
        end
        fr_phase = lfbd_pkg::PH_HUNT;
      end
    endcase
  endfunction

  // Offer one byte, wait for it to be taken, then record what it causes
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind,
                           input logic [7:0] pb);
    payload_word_t w;
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
    deframe_byte(b);
    case (kind)
      ROW_PRED: foreach (frame_words[i]) expected_words.push_back(frame_words[i]);
      ROW_ONE: begin
        w.pb  = pb;
        w.idx = 6'd0;
        w.lst = 1'b1;
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  // Send one frame with random payload; return the number of bytes sent
  task automatic send_frame(input logic [7:0] len, input logic [7:0] end_b,
                            output int n_bytes);
    int n_pay;
    n_pay = (len > lfbd_pkg::LEN_OVERHEAD) ? int'(len - lfbd_pkg::LEN_OVERHEAD) : 1;
    send_byte(lfbd_pkg::START_BYTE, ROW_PRED, 8'h00);
    send_byte(len, ROW_PRED, 8'h00);
    repeat (n_pay) send_byte(8'($urandom_range(0, 255)), ROW_PRED, 8'h00);
    send_byte(end_b, ROW_PRED, 8'h00);
    n_bytes = n_pay + 3;
  endtask

  // Mostly well-formed frames with random content, some noise and broken ones
  task automatic random_traffic(input int budget);
    int sent;
    int n;
    int r;
    logic [7:0] len;
    logic [7:0] end_b;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // hunting noise; does not count toward the budget
        send_byte(8'($urandom_range(0, 253)), ROW_PRED, 8'h00);
      end else if (r < 14) begin
        // truncated frame: the next start byte lands inside it
        send_byte(lfbd_pkg::START_BYTE, ROW_PRED, 8'h00);
        send_byte(8'($urandom_range(8, 30)), ROW_PRED, 8'h00);
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)), ROW_PRED, 8'h00);
        sent += n + 2;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6)       len = 8'($urandom_range(0, 3));
        else if (r < 14) len = 8'($urandom_range(60, 72));
        else             len = 8'($urandom_range(4, 20));
        r = $urandom_range(0, 99);
        if (r < 88)      end_b = lfbd_pkg::END_BYTE;
        else if (r < 94) end_b = lfbd_pkg::START_BYTE;
        else             end_b = 8'($urandom_range(0, 255));
        send_frame(len, end_b, n);
        sent += n;
      end
    end
  endtask

  // Pause the sender until every expected word has come out
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (END_LAT) @(posedge clk);
  endtask

  task automatic note_error(input string what, input payload_word_t exp_w);
    err_cnt++;
    if (err_cnt <= MAX_REPORT)
      $display("%0t: %s: expected byte %02h index %0d last %0b, %s %02h index %0d last %0b",
               $realtime, what, exp_w.pb, exp_w.idx, exp_w.lst, "got byte",
               out_payload_byte, out_byte_index, out_last);
  endtask

  // Output ready: random stalls, forced low during a hold-off
  always @(posedge clk) begin
    out_ready <= !hold_on && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Check each taken output word against the oldest expectation
  always @(posedge clk) begin : check_out
    payload_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        w = '0;
        note_error("output word with none expected", w);
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (out_payload_byte !== w.pb || out_byte_index !== w.idx ||
            out_last !== w.lst)
          note_error("payload word mismatch", w);
      end
    end
  end

  initial begin : stimulus
    int n;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, no idling
    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].kind, DIR_ROWS[i].pb);
    drain();

    // Length extremes: largest frame sent, one past it, smallest long length
    send_frame(8'(lfbd_pkg::EMIT_LIMIT + 3), lfbd_pkg::END_BYTE, n);
    send_frame(8'(lfbd_pkg::EMIT_LIMIT + 4), lfbd_pkg::END_BYTE, n);
    send_frame(8'd4, lfbd_pkg::END_BYTE, n);
    drain();

    // Random traffic under several idle patterns
    random_traffic(20);
    src_idle_pct = 69;
    random_traffic(20);
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 69;
    random_traffic(20);
    src_idle_pct   = 9;
    sink_stall_pct = 9;
    random_traffic(20);
    drain();

    // Long output hold-off while short frames keep arriving
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (6) send_frame(8'($urandom_range(5, 9)), lfbd_pkg::END_BYTE, n);
    drain();

    $display("sent %0d input bytes, checked %0d payload words", words_in, words_checked);
    $display("covered short and extreme lengths, dropped frames, idle and hold-off phases");
    if (err_cnt == 0) begin
      $display("length_framed_byte_deframer_tb OK");
    end else begin
      $display("%0d errors", err_cnt);
      $display("length_framed_byte_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lfbd_pkg.sv
rtl/lfbd_ram.sv
rtl/lfbd_front.sv
rtl/lfbd_queue.sv
rtl/lfbd_back.sv
rtl/length_framed_byte_deframer.sv
tb/length_framed_byte_deframer_tb.sv
